// ===== rtl/fpp_pkg.sv =====
package fpp_pkg;

   // Default sizes of the canvas and of the word store
   localparam int DEFAULT_MAX_WIDTH   = 128;
   localparam int DEFAULT_MAX_HEIGHT  = 64;
   localparam int DEFAULT_STORE_DEPTH = 8192;

   // Word address and region count widths (cover the largest canvas and store)
   localparam int ADDR_W  = 16;
   localparam int LIMIT_W = 17;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_LAYOUT_MODE      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CANVAS_WIDTH     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CANVAS_HEIGHT    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FOREGROUND_INDEX = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BACKGROUND_INDEX = 3'd4;

   typedef enum logic [1:0] {
      OP_PLOT  = 2'd0,
      OP_FILL  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      MODE_MONO_H = 2'd0,
      MODE_MONO_V = 2'd1,
      MODE_INDEX8 = 2'd2,
      MODE_RGB565 = 2'd3
   } mode_type;

   typedef struct packed {
      mode_type    layout_mode;
      logic [7:0]  canvas_width;
      logic [6:0]  canvas_height;
      logic [4:0]  foreground_index;
      logic [4:0]  background_index;
   } cfg_type;

   typedef struct packed {
      op_type              op;
      logic signed [15:0]  pos_x;
      logic signed [15:0]  pos_y;
      logic [4:0]          colour_index;
      logic [12:0]         read_address;
   } req_type;

   // Address unit result for one transaction
   typedef struct packed {
      logic               on_canvas;
      logic               in_store;
      logic [ADDR_W-1:0]  addr;
      logic [LIMIT_W-1:0] limit;
      logic [7:0]         mask;
      logic               set_bit;
      logic [15:0]        value;
   } geom_type;

   // Fixed RGB565 palette; unlisted indices give black
   function automatic logic [15:0] palette565(input logic [4:0] c);
      logic [15:0] v;
      unique case (c)
         5'd0:    v = 16'h0000;
         5'd1:    v = 16'hFFFF;
         5'd2:    v = 16'hF800;
         5'd3:    v = 16'h07E0;
         5'd4:    v = 16'h001F;
         5'd5:    v = 16'hFFE0;
         5'd6:    v = 16'h07FF;
         5'd7:    v = 16'hF81F;
         5'd8:    v = 16'hC618;
         5'd9:    v = 16'h8410;
         5'd10:   v = 16'h8000;
         5'd11:   v = 16'hA145;
         5'd12:   v = 16'h8400;
         5'd13:   v = 16'h0400;
         5'd14:   v = 16'hAFE0;
         5'd15:   v = 16'h8010;
         5'd16:   v = 16'h0410;
         5'd17:   v = 16'h0010;
         5'd18:   v = 16'hFDAB;
         5'd19:   v = 16'hFEA0;
         5'd20:   v = 16'h2444;
         default: v = 16'h0000;
      endcase
      return v;
   endfunction

endpackage

// ===== rtl/fpp_channels.sv =====
interface fpp_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         op;
   logic signed [15:0] pos_x;
   logic signed [15:0] pos_y;
   logic [4:0]         colour_index;
   logic [12:0]        read_address;

   modport source (output valid, output op, output pos_x, output pos_y,
                   output colour_index, output read_address, input ready);
   modport sink (input valid, input op, input pos_x, input pos_y,
                 input colour_index, input read_address, output ready);
endinterface

interface fpp_rsp_if;
   logic        valid;
   logic        ready;
   logic        was_inside;
   logic [15:0] read_word;

   modport source (output valid, output was_inside, output read_word, input ready);
   modport sink (input valid, input was_inside, input read_word, output ready);
endinterface

// ===== rtl/fpp_ram.sv =====
module fpp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/fpp_geom.sv =====
module fpp_geom #(
   parameter int MAX_WIDTH   = fpp_pkg::DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT  = fpp_pkg::DEFAULT_MAX_HEIGHT,
   parameter int STORE_DEPTH = fpp_pkg::DEFAULT_STORE_DEPTH
) (
   input  logic              clock,
   input  logic              load,
   input  fpp_pkg::cfg_type  cfg,
   input  fpp_pkg::req_type  req,
   output fpp_pkg::geom_type geom
);

   localparam logic [7:0]                  MaxW   = 8'(MAX_WIDTH);
   localparam logic [7:0]                  MaxH   = 8'(MAX_HEIGHT);
   localparam logic [fpp_pkg::LIMIT_W-1:0] DepthL = fpp_pkg::LIMIT_W'(STORE_DEPTH);

   logic [7:0]                  height_ext;
   logic [7:0]                  w;
   logic [7:0]                  h;
   logic [5:0]                  row_bytes;
   logic [5:0]                  pages;
   logic [7:0]                  ux;
   logic [7:0]                  uy;
   logic                        is_plot;
   logic                        mono_h;
   logic                        mono_v;
   logic [7:0]                  mul_a;
   logic [7:0]                  mul_b;
   logic [7:0]                  mul_add;
   logic [15:0]                 product;
   logic [fpp_pkg::LIMIT_W-1:0] sum;
   fpp_pkg::geom_type           geom_in;
   fpp_pkg::geom_type           geom_ff;

   // Clamp the canvas and derive the byte-packed row and page counts
   always_comb begin
      height_ext = {1'b0, cfg.canvas_height};
      w          = (cfg.canvas_width > MaxW) ? MaxW : cfg.canvas_width;
      h          = (height_ext > MaxH) ? MaxH : height_ext;
      row_bytes  = 6'((9'(w) + 9'd7) >> 3);
      pages      = 6'((9'(h) + 9'd7) >> 3);
      ux         = req.pos_x[7:0];
      uy         = req.pos_y[7:0];
      is_plot    = (req.op == fpp_pkg::OP_PLOT);
      mono_h     = (cfg.layout_mode == fpp_pkg::MODE_MONO_H);
      mono_v     = (cfg.layout_mode == fpp_pkg::MODE_MONO_V);
   end

   // One multiply-add: pixel word address for a plot, region size otherwise
   always_comb begin
      mul_b = mono_h ? {2'b00, row_bytes} : w;
      if (is_plot) begin
         mul_a   = mono_v ? {3'b000, uy[7:3]} : uy;
         mul_add = mono_h ? {3'b000, ux[7:3]} : ux;
      end else begin
         mul_a   = mono_v ? {2'b00, pages} : h;
         mul_add = 8'h00;
      end
      product = mul_a * mul_b;
      sum     = fpp_pkg::LIMIT_W'(product) + fpp_pkg::LIMIT_W'(mul_add);
   end

   // Bounds, bit mask and the word value for plot and fill
   always_comb begin
      geom_in.on_canvas = !req.pos_x[15] && !req.pos_y[15] &&
                          ($unsigned(req.pos_x) < {8'h00, w}) &&
                          ($unsigned(req.pos_y) < {8'h00, h});
      geom_in.addr      = sum[fpp_pkg::ADDR_W-1:0];
      geom_in.in_store  = (sum < DepthL);
      geom_in.limit     = geom_in.in_store ? sum : DepthL;
      geom_in.mask      = mono_h ? (8'h80 >> ux[2:0]) : (8'h01 << uy[2:0]);
      geom_in.set_bit   = mono_h ? (req.colour_index == cfg.foreground_index)
                                 : (req.colour_index != 5'd0);
      unique case (cfg.layout_mode)
         fpp_pkg::MODE_MONO_H:
            geom_in.value = (req.colour_index == cfg.background_index) ? 16'h0000 : 16'h00FF;
         fpp_pkg::MODE_MONO_V:
            geom_in.value = (req.colour_index == 5'd0) ? 16'h0000 : 16'h00FF;
         fpp_pkg::MODE_INDEX8:
            geom_in.value = {11'd0, req.colour_index};
         fpp_pkg::MODE_RGB565:
            geom_in.value = fpp_pkg::palette565(req.colour_index);
      endcase
   end

   // Hold the result for the execute steps
   always_ff @(posedge clock) begin
      if (load) begin
         geom_ff <= geom_in;
      end
   end

   assign geom = geom_ff;

endmodule

// ===== rtl/framebuffer_pixel_plotter.sv =====
// Frame store pixel plotter: keeps one canvas in a single-port-write,
// registered-read word store (STORE_DEPTH x 16) in one of four layouts and
// executes plot, fill, clear and read-word commands one transaction at a
// time, each giving one response. An accepted command passes through the
// calculate and execute steps to the completion step; a plot that lands
// in the store in a mono layout reads, modifies and writes back the store
// byte in an extra step, a read word inside the store reads the word in
// an extra step, and fill or clear walk the canvas region one store word
// per cycle through the store's write port. After reset the block runs a
// clearing pass that zeroes the store; req_chan.ready stays low until it
// finishes, while configuration writes are taken at any time. A finished
// response waits in an output register, and the next command may be
// accepted while it is pending.
module framebuffer_pixel_plotter #(
   parameter int MAX_WIDTH   = fpp_pkg::DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT  = fpp_pkg::DEFAULT_MAX_HEIGHT,
   parameter int STORE_DEPTH = fpp_pkg::DEFAULT_STORE_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   fpp_req_if.sink                         req_chan,
   fpp_rsp_if.source                       rsp_chan,
   input  logic                            csr_wr_en,
   input  logic [fpp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [fpp_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int                          IDX_W  = $clog2(STORE_DEPTH);
   localparam logic [fpp_pkg::LIMIT_W-1:0] DepthL = fpp_pkg::LIMIT_W'(STORE_DEPTH);

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_CALC,
      ST_EXEC,
      ST_MODIFY,
      ST_READ,
      ST_WALK,
      ST_DONE
   } state_type;

   state_type                   state_ff, state_in;
   logic [fpp_pkg::LIMIT_W-1:0] cursor_ff, cursor_in;
   logic [fpp_pkg::LIMIT_W-1:0] walk_limit_ff, walk_limit_in;
   logic [15:0]                 walk_value_ff, walk_value_in;
   fpp_pkg::req_type            req_ff, req_in;
   fpp_pkg::cfg_type            cfg_ff, cfg_in;
   logic                        res_inside_ff, res_inside_in;
   logic [15:0]                 res_word_ff, res_word_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_inside_ff, rsp_inside_in;
   logic [15:0]                 rsp_word_ff, rsp_word_in;

   fpp_pkg::geom_type           geom;
   logic                        geom_load;
   logic                        mem_wr_en;
   logic [IDX_W-1:0]            mem_wr_idx;
   logic [15:0]                 mem_wr_data;
   logic                        mem_rd_en;
   logic [IDX_W-1:0]            mem_rd_idx;
   logic [15:0]                 mem_rd_data;
   logic [fpp_pkg::ADDR_W-1:0]  read_addr_ext;
   logic                        read_in_store;
   logic [7:0]                  modified_byte;

   fpp_geom #(
      .MAX_WIDTH   (MAX_WIDTH),
      .MAX_HEIGHT  (MAX_HEIGHT),
      .STORE_DEPTH (STORE_DEPTH)
   ) u_geom (
      .clock (clock),
      .load  (geom_load),
      .cfg   (cfg_ff),
      .req   (req_ff),
      .geom  (geom)
   );

   fpp_ram #(
      .WIDTH (16),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_idx),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_idx),
      .rd_data (mem_rd_data)
   );

   // Read-word address and mono byte update
   always_comb begin
      read_addr_ext = {3'b000, req_ff.read_address};
      read_in_store = ({4'b0000, req_ff.read_address} < DepthL);
      modified_byte = geom.set_bit ? (mem_rd_data[7:0] | geom.mask)
                                   : (mem_rd_data[7:0] & ~geom.mask);
   end

   // Command sequencer, store access and configuration
   always_comb begin
      state_in      = state_ff;
      cursor_in     = cursor_ff;
      walk_limit_in = walk_limit_ff;
      walk_value_in = walk_value_ff;
      req_in        = req_ff;
      cfg_in        = cfg_ff;
      res_inside_in = res_inside_ff;
      res_word_in   = res_word_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_inside_in = rsp_inside_ff;
      rsp_word_in   = rsp_word_ff;
      geom_load     = 1'b0;
      mem_wr_en     = 1'b0;
      mem_wr_idx    = cursor_ff[IDX_W-1:0];
      mem_wr_data   = 16'h0000;
      mem_rd_en     = 1'b0;
      mem_rd_idx    = geom.addr[IDX_W-1:0];

      // Drop a delivered response
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      // Register writes
      if (csr_wr_en) begin
         unique case (csr_index)
            fpp_pkg::CSR_LAYOUT_MODE:
               cfg_in.layout_mode = fpp_pkg::mode_type'(csr_wdata[1:0]);
            fpp_pkg::CSR_CANVAS_WIDTH:     cfg_in.canvas_width     = csr_wdata;
            fpp_pkg::CSR_CANVAS_HEIGHT:    cfg_in.canvas_height    = csr_wdata[6:0];
            fpp_pkg::CSR_FOREGROUND_INDEX: cfg_in.foreground_index = csr_wdata[4:0];
            fpp_pkg::CSR_BACKGROUND_INDEX: cfg_in.background_index = csr_wdata[4:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         // Zero the whole store, one word per cycle
         ST_INIT: begin
            mem_wr_en = 1'b1;
            cursor_in = cursor_ff + 1'b1;
            if (cursor_ff == DepthL - 1'b1) begin
               cursor_in = '0;
               state_in  = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_chan.valid) begin
               req_in.op           = fpp_pkg::op_type'(req_chan.op);
               req_in.pos_x        = req_chan.pos_x;
               req_in.pos_y        = req_chan.pos_y;
               req_in.colour_index = req_chan.colour_index;
               req_in.read_address = req_chan.read_address;
               state_in            = ST_CALC;
            end
         end
         ST_CALC: begin
            geom_load = 1'b1;
            state_in  = ST_EXEC;
         end
         ST_EXEC: begin
            res_inside_in = 1'b0;
            res_word_in   = 16'h0000;
            unique case (req_ff.op)
               fpp_pkg::OP_PLOT: begin
                  res_inside_in = geom.on_canvas;
                  state_in      = ST_DONE;
                  if (geom.on_canvas && geom.in_store) begin
                     if (cfg_ff.layout_mode == fpp_pkg::MODE_MONO_H ||
                         cfg_ff.layout_mode == fpp_pkg::MODE_MONO_V) begin
                        mem_rd_en = 1'b1;
                        state_in  = ST_MODIFY;
                     end else begin
                        mem_wr_en   = 1'b1;
                        mem_wr_idx  = geom.addr[IDX_W-1:0];
                        mem_wr_data = geom.value;
                     end
                  end
               end
               fpp_pkg::OP_FILL, fpp_pkg::OP_CLEAR: begin
                  walk_value_in = (req_ff.op == fpp_pkg::OP_CLEAR) ? 16'h0000 : geom.value;
                  walk_limit_in = geom.limit;
                  cursor_in     = '0;
                  state_in      = ST_WALK;
               end
               fpp_pkg::OP_READ: begin
                  state_in = ST_DONE;
                  if (read_in_store) begin
                     mem_rd_en  = 1'b1;
                     mem_rd_idx = read_addr_ext[IDX_W-1:0];
                     state_in   = ST_READ;
                  end
               end
            endcase
         end
         // Write back the updated mono byte
         ST_MODIFY: begin
            mem_wr_en   = 1'b1;
            mem_wr_idx  = geom.addr[IDX_W-1:0];
            mem_wr_data = {8'h00, modified_byte};
            state_in    = ST_DONE;
         end
         ST_READ: begin
            res_word_in = mem_rd_data;
            state_in    = ST_DONE;
         end
         // Walk the canvas region from word zero
         ST_WALK: begin
            if (cursor_ff < walk_limit_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_data = walk_value_ff;
               cursor_in   = cursor_ff + 1'b1;
            end else begin
               cursor_in = '0;
               state_in  = ST_DONE;
            end
         end
         // Hand the result to the output register once it is free
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_inside_in = res_inside_ff;
               rsp_word_in   = res_word_ff;
               state_in      = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      walk_limit_ff <= walk_limit_in;
      walk_value_ff <= walk_value_in;
      req_ff        <= req_in;
      res_inside_ff <= res_inside_in;
      res_word_ff   <= res_word_in;
      rsp_inside_ff <= rsp_inside_in;
      rsp_word_ff   <= rsp_word_in;
      if (reset) begin
         state_ff                <= ST_INIT;
         cursor_ff               <= '0;
         rsp_valid_ff            <= 1'b0;
         cfg_ff.layout_mode      <= fpp_pkg::MODE_MONO_H;
         cfg_ff.canvas_width     <= 8'd128;
         cfg_ff.canvas_height    <= 7'd64;
         cfg_ff.foreground_index <= 5'd1;
         cfg_ff.background_index <= 5'd0;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   assign req_chan.ready      = (state_ff == ST_IDLE);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.was_inside = rsp_inside_ff;
   assign rsp_chan.read_word  = rsp_word_ff;

   // A plot outside the canvas leaves the store untouched
   a_outside_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC && req_ff.op == fpp_pkg::OP_PLOT && !geom.on_canvas)
         |-> !mem_wr_en)
      else $error("store written by a plot outside the canvas");

   // The walk cursor is back at zero between commands
   a_cursor_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (cursor_ff == '0))
      else $error("walk cursor not returned to zero");

   // A response appears only out of the completion step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside completion");

endmodule

// ===== tb/sv/tb.sv =====
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STORE_WORDS    = fpp_pkg::DEFAULT_STORE_DEPTH;
   localparam int MAX_W          = fpp_pkg::DEFAULT_MAX_WIDTH;
   localparam int MAX_H          = fpp_pkg::DEFAULT_MAX_HEIGHT;
   localparam int WATCHDOG_LIMIT = 60000;
   localparam int PHASE_COUNT    = 12;
   localparam int PHASE_ITEMS    = 64;

   typedef struct packed {
      logic        was_inside;
      logic [15:0] read_word;
   } pixel_rsp_type;

   typedef struct {
      fpp_pkg::req_type cmd;
      bit               has_gold;
      pixel_rsp_type    gold;
   } script_row_type;

   typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_kind_type;

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           csr_wr_en;
   logic [fpp_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [fpp_pkg::CSR_DATA_W-1:0] csr_wdata;

   fpp_req_if req_chan ();
   fpp_rsp_if rsp_chan ();

   framebuffer_pixel_plotter dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow copy of the canvas store and registers
   logic [15:0]      model_store [STORE_WORDS];
   fpp_pkg::cfg_type model_cfg;
   int               last_plot_addr = 0;

   pixel_rsp_type  expected_rsp [$];
   script_row_type script [$];
   idle_kind_type  idle_kind = IDLE_NONE;
   int             mismatch_count = 0;
   int             quiet_cycles = 0;

   always #4 clock = ~clock;

   // Palette entries as 8-bit RGB, packed down to 565
   function automatic logic [15:0] palette_color(input logic [4:0] c);
      logic [23:0] rgb;
      case (c)
         5'd0:    rgb = 24'h000000;
         5'd1:    rgb = 24'hFFFFFF;
         5'd2:    rgb = 24'hFF0000;
         5'd3:    rgb = 24'h00FF00;
         5'd4:    rgb = 24'h0000FF;
         5'd5:    rgb = 24'hFFFF00;
         5'd6:    rgb = 24'h00FFFF;
         5'd7:    rgb = 24'hFF00FF;
         5'd8:    rgb = 24'hC0C0C0;
         5'd9:    rgb = 24'h808080;
         5'd10:   rgb = 24'h800000;
         5'd11:   rgb = 24'hA52A2A;
         5'd12:   rgb = 24'h808000;
         5'd13:   rgb = 24'h008000;
         5'd14:   rgb = 24'hAAFF00;
         5'd15:   rgb = 24'h800080;
         5'd16:   rgb = 24'h008080;
         5'd17:   rgb = 24'h000080;
         5'd18:   rgb = 24'hFFB45A;
         5'd19:   rgb = 24'hFFD700;
         5'd20:   rgb = 24'h228B22;
         default: rgb = 24'h000000;
      endcase
      return {rgb[23:19], rgb[15:10], rgb[7:3]};
   endfunction

   // Clamp the canvas to the built-in maximum
   function automatic int eff_w();
      return (int'(model_cfg.canvas_width) > MAX_W) ? MAX_W : int'(model_cfg.canvas_width);
   endfunction

   function automatic int eff_h();
      return (int'(model_cfg.canvas_height) > MAX_H) ? MAX_H : int'(model_cfg.canvas_height);
   endfunction

   function automatic int region_words();
      case (model_cfg.layout_mode)
         fpp_pkg::MODE_MONO_H: return eff_h() * ((eff_w() + 7) / 8);
         fpp_pkg::MODE_MONO_V: return eff_w() * ((eff_h() + 7) / 8);
         default:              return eff_w() * eff_h();
      endcase
   endfunction

   function automatic logic [15:0] read_model(input int addr);
      return (addr < STORE_WORDS) ? model_store[addr] : 16'h0000;
   endfunction

   function automatic void write_model(input int addr, input logic [15:0] v);
      if (addr < STORE_WORDS) model_store[addr] = v;
   endfunction

   function automatic void fill_region(input logic [15:0] v);
      int n;
      n = region_words();
      for (int i = 0; i < n; i++) write_model(i, v);
   endfunction

   // Execute one command on the shadow store and return its response
   function automatic pixel_rsp_type apply_cmd(input fpp_pkg::req_type cmd);
      pixel_rsp_type res;
      int            x, y, w, h, addr;
      logic [15:0]   word, mask;
      res  = '0;
      w    = eff_w();
      h    = eff_h();
      x    = int'($signed(cmd.pos_x));
      y    = int'($signed(cmd.pos_y));
      addr = 0;
      case (cmd.op)
         fpp_pkg::OP_PLOT: begin
            if (x >= 0 && y >= 0 && x < w && y < h) begin
               res.was_inside = 1'b1;
               case (model_cfg.layout_mode)
                  fpp_pkg::MODE_MONO_H: begin
                     addr = y * ((w + 7) / 8) + x / 8;
                     mask = 16'h0080 >> (x % 8);
                     word = read_model(addr);
                     word = (cmd.colour_index == model_cfg.foreground_index) ?
                            (word | mask) : (word & ~mask);
                     write_model(addr, word & 16'h00FF);
                  end
                  fpp_pkg::MODE_MONO_V: begin
                     addr = (y / 8) * w + x;
                     mask = 16'h0001 << (y % 8);
                     word = read_model(addr);
                     word = (cmd.colour_index != 5'd0) ? (word | mask) : (word & ~mask);
                     write_model(addr, word & 16'h00FF);
                  end
                  fpp_pkg::MODE_INDEX8: begin
                     addr = y * w + x;
                     write_model(addr, 16'(cmd.colour_index));
                  end
                  default: begin
                     addr = y * w + x;
                     write_model(addr, palette_color(cmd.colour_index));
                  end
               endcase
               last_plot_addr = addr;
            end
         end
         fpp_pkg::OP_FILL: begin
            case (model_cfg.layout_mode)
               fpp_pkg::MODE_MONO_H:
                  fill_region((cmd.colour_index == model_cfg.background_index) ?
                              16'h0000 : 16'h00FF);
               fpp_pkg::MODE_MONO_V:
                  fill_region((cmd.colour_index == 5'd0) ? 16'h0000 : 16'h00FF);
               fpp_pkg::MODE_INDEX8:
                  fill_region(16'(cmd.colour_index));
               default:
                  fill_region(palette_color(cmd.colour_index));
            endcase
         end
         fpp_pkg::OP_CLEAR: fill_region(16'h0000);
         default:           res.read_word = read_model(int'(cmd.read_address));
      endcase
      return res;
   endfunction

   function automatic void add_row(input fpp_pkg::op_type op, input int x, input int y,
                                   input int c, input int a, input bit g,
                                   input logic on_canvas, input logic [15:0] word);
      script_row_type row;
      row.cmd.op              = op;
      row.cmd.pos_x           = 16'(x);
      row.cmd.pos_y           = 16'(y);
      row.cmd.colour_index    = 5'(c);
      row.cmd.read_address    = 13'(a);
      row.has_gold            = g;
      row.gold.was_inside     = on_canvas;
      row.gold.read_word      = word;
      script.push_back(row);
   endfunction

   // Write one register and mirror it into the shadow registers
   task automatic write_reg(input logic [fpp_pkg::CSR_IDX_W-1:0] idx, input int value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= fpp_pkg::CSR_DATA_W'(value);
      case (idx)
         fpp_pkg::CSR_LAYOUT_MODE:
            model_cfg.layout_mode      = fpp_pkg::mode_type'(value[1:0]);
         fpp_pkg::CSR_CANVAS_WIDTH:
            model_cfg.canvas_width     = 8'(value);
         fpp_pkg::CSR_CANVAS_HEIGHT:
            model_cfg.canvas_height    = 7'(value);
         fpp_pkg::CSR_FOREGROUND_INDEX:
            model_cfg.foreground_index = 5'(value);
         fpp_pkg::CSR_BACKGROUND_INDEX:
            model_cfg.background_index = 5'(value);
         default: ;
      endcase
      @(negedge clock);
   endtask

   // Offer one command, hold it until accepted, then queue its response
   task automatic send_req(input fpp_pkg::req_type cmd, input bit has_gold,
                           input pixel_rsp_type gold);
      pixel_rsp_type want;
      while ((idle_kind == IDLE_SENDER && $urandom_range(99) < 56) ||
             (idle_kind == IDLE_BOTH && $urandom_range(99) < 26)) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.op           <= cmd.op;
      req_chan.pos_x        <= cmd.pos_x;
      req_chan.pos_y        <= cmd.pos_y;
      req_chan.colour_index <= cmd.colour_index;
      req_chan.read_address <= cmd.read_address;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      want = apply_cmd(cmd);
      if (has_gold) want = gold;
      expected_rsp.push_back(want);
      @(negedge clock);
   endtask

   // Stall the response side according to the current phase
   always @(negedge clock) begin
      case (idle_kind)
         IDLE_RECEIVER: rsp_chan.ready <= ($urandom_range(99) >= 56);
         IDLE_BOTH:     rsp_chan.ready <= ($urandom_range(99) >= 26);
         default:       rsp_chan.ready <= 1'b1;
      endcase
   end

   // Compare each response transaction with the oldest expectation
   always @(posedge clock) begin
      pixel_rsp_type want;
      if (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (expected_rsp.size() == 0) begin
            $display("%0t: unexpected response was_inside=%0b read_word=%h", $time,
                     rsp_chan.was_inside, rsp_chan.read_word);
            mismatch_count++;
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_chan.was_inside !== want.was_inside) begin
               $display("%0t: was_inside expected %0b actual %0b", $time,
                        want.was_inside, rsp_chan.was_inside);
               mismatch_count++;
            end
            if (rsp_chan.read_word !== want.read_word) begin
               $display("%0t: read_word expected %h actual %h", $time,
                        want.read_word, rsp_chan.read_word);
               mismatch_count++;
            end
         end
      end
   end

   // Abort when no transaction moves for too long
   always @(posedge clock) begin
      if ((req_chan.valid === 1'b1 && req_chan.ready === 1'b1) ||
          (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      int mode, width, height, fg, bg;

      // Drive every input to a known value and hold reset
      reset                 = 1'b1;
      csr_wr_en             = 1'b0;
      csr_index             = '0;
      csr_wdata             = '0;
      req_chan.valid        = 1'b0;
      req_chan.op           = fpp_pkg::OP_PLOT;
      req_chan.pos_x        = '0;
      req_chan.pos_y        = '0;
      req_chan.colour_index = '0;
      req_chan.read_address = '0;
      rsp_chan.ready        = 1'b0;
      for (int i = 0; i < STORE_WORDS; i++) model_store[i] = 16'h0000;
      model_cfg = '{layout_mode: fpp_pkg::MODE_MONO_H, canvas_width: 8'd128,
                    canvas_height: 7'd64, foreground_index: 5'd1,
                    background_index: 5'd0};

      // Directed commands in the reset layout: mono horizontal, 128 x 64
      add_row(fpp_pkg::OP_READ,  0, 0, 0, 0, 1, 1'b0, 16'h0000);
      add_row(fpp_pkg::OP_READ,  -1, -1, 31, 8191, 1, 1'b0, 16'h0000);
      add_row(fpp_pkg::OP_PLOT,  0, 0, 1, 8191, 1, 1'b1, 16'h0000);
      add_row(fpp_pkg::OP_READ,  0, 0, 0, 0, 1, 1'b0, 16'h0080);
      add_row(fpp_pkg::OP_PLOT,  127, 63, 1, 0, 1, 1'b1, 16'h0000);
      add_row(fpp_pkg::OP_READ,  0, 0, 0, 1023, 1, 1'b0, 16'h0001);
      add_row(fpp_pkg::OP_PLOT,  -1, 0, 1, 0, 1, 1'b0, 16'h0000);
      add_row(fpp_pkg::OP_PLOT,  128, 0, 1, 0, 1, 1'b0, 16'h0000);
      add_row(fpp_pkg::OP_PLOT,  0, 64, 1, 0, 1, 1'b0, 16'h0000);
      add_row(fpp_pkg::OP_PLOT,  -32768, 32767, 1, 0, 1, 1'b0, 16'h0000);
      add_row(fpp_pkg::OP_PLOT,  32767, -32768, 1, 0, 1, 1'b0, 16'h0000);
      add_row(fpp_pkg::OP_PLOT,  0, 0, 0, 0, 1, 1'b1, 16'h0000);
      add_row(fpp_pkg::OP_READ,  0, 0, 0, 0, 1, 1'b0, 16'h0000);
      add_row(fpp_pkg::OP_PLOT,  100, 40, 1, 0, 0, 1'b0, 16'h0000);
      add_row(fpp_pkg::OP_READ,  0, 0, 0, 652, 0, 1'b0, 16'h0000);
      add_row(fpp_pkg::OP_FILL,  0, 0, 31, 0, 1, 1'b0, 16'h0000);
      add_row(fpp_pkg::OP_READ,  0, 0, 0, 1023, 1, 1'b0, 16'h00FF);
      add_row(fpp_pkg::OP_READ,  0, 0, 0, 1024, 1, 1'b0, 16'h0000);
      add_row(fpp_pkg::OP_PLOT,  9, 2, 5, 0, 1, 1'b1, 16'h0000);
      add_row(fpp_pkg::OP_READ,  0, 0, 0, 33, 1, 1'b0, 16'h00BF);
      add_row(fpp_pkg::OP_FILL,  0, 0, 0, 0, 1, 1'b0, 16'h0000);
      add_row(fpp_pkg::OP_READ,  0, 0, 0, 33, 1, 1'b0, 16'h0000);
      add_row(fpp_pkg::OP_FILL,  0, 0, 17, 0, 1, 1'b0, 16'h0000);
      add_row(fpp_pkg::OP_CLEAR, 0, 0, 0, 0, 1, 1'b0, 16'h0000);
      add_row(fpp_pkg::OP_READ,  0, 0, 0, 5, 1, 1'b0, 16'h0000);

      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // Walk the directed table
      foreach (script[i]) send_req(script[i].cmd, script[i].has_gold, script[i].gold);
      req_chan.valid <= 1'b0;

      // Random phases, each with its own layout and idling pattern
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         while (expected_rsp.size() != 0) @(negedge clock);
         idle_kind = idle_kind_type'(phase % 4);

         mode   = $urandom_range(3);
         width  = $urandom_range(1, 40);
         height = $urandom_range(1, 24);
         fg     = $urandom_range(31);
         bg     = $urandom_range(31);
         if ($urandom_range(9) == 0) begin
            width  = $urandom_range(255);
            height = $urandom_range(127);
         end
         // Open with layout changes, clamped, empty and odd-sized canvases
         case (phase)
            0: begin mode = fpp_pkg::MODE_MONO_V; width = 128; height = 64; end
            1: begin mode = fpp_pkg::MODE_INDEX8; width = 255; height = 127; end
            2: begin mode = fpp_pkg::MODE_RGB565; width = 0; height = 5; end
            3: begin
               mode = fpp_pkg::MODE_MONO_H; width = 5; height = 0; fg = 0; bg = 31;
            end
            4: begin mode = fpp_pkg::MODE_RGB565; width = 1; height = 1; end
            5: begin
               mode = fpp_pkg::MODE_MONO_H; width = 13; height = 9; fg = 31; bg = 31;
            end
            6: begin mode = fpp_pkg::MODE_MONO_V; width = 17; height = 11; end
            default: ;
         endcase
         write_reg(fpp_pkg::CSR_LAYOUT_MODE, mode);
         write_reg(fpp_pkg::CSR_CANVAS_WIDTH, width);
         write_reg(fpp_pkg::CSR_CANVAS_HEIGHT, height);
         write_reg(fpp_pkg::CSR_FOREGROUND_INDEX, fg);
         write_reg(fpp_pkg::CSR_BACKGROUND_INDEX, bg);
         csr_wr_en <= 1'b0;

         for (int item = 0; item < PHASE_ITEMS; item++) begin
            fpp_pkg::req_type cmd;
            int               pick, fill_pct, region;
            cmd.op           = fpp_pkg::OP_READ;
            cmd.pos_x        = 16'($urandom);
            cmd.pos_y        = 16'($urandom);
            cmd.colour_index = 5'($urandom);
            cmd.read_address = 13'($urandom);
            region   = region_words();
            // Keep walks rare on large regions
            fill_pct = (region > 1024) ? 2 : 8;
            pick     = $urandom_range(99);
            if (pick < fill_pct)
               cmd.op = fpp_pkg::OP_FILL;
            else if (pick < fill_pct + fill_pct / 2)
               cmd.op = fpp_pkg::OP_CLEAR;
            else if (pick < 60)
               cmd.op = fpp_pkg::OP_PLOT;
            // Favor the colours that steer the mono layouts
            pick = $urandom_range(9);
            if (pick < 4)
               cmd.colour_index = model_cfg.foreground_index;
            else if (pick < 6)
               cmd.colour_index = model_cfg.background_index;
            else if (pick < 7)
               cmd.colour_index = 5'd0;
            // Aim most plots at the canvas and its border
            if (cmd.op == fpp_pkg::OP_PLOT && $urandom_range(4) != 0) begin
               cmd.pos_x = 16'(int'($urandom_range(eff_w() + 1)) - 1);
               cmd.pos_y = 16'(int'($urandom_range(eff_h() + 1)) - 1);
            end
            // Read back the last plotted word most of the time
            if (cmd.op == fpp_pkg::OP_READ) begin
               pick = $urandom_range(9);
               if (pick < 6)
                  cmd.read_address = 13'(last_plot_addr);
               else if (pick < 9)
                  cmd.read_address = 13'($urandom_range(region + 1));
            end
            send_req(cmd, 1'b0, '0);
         end
         req_chan.valid <= 1'b0;
      end

      // Drain outstanding responses, then let the block settle
      while (expected_rsp.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
